// ----- src/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PVS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define PVS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/pvs_pkg.sv -----
`timescale 1ns / 1ps
package pvs_pkg;

  // Group and exponent moduli, with 2^20 mod P and 2^18 mod Q for folding
  parameter logic [19:0] GROUP_P = 20'd1000003;
  parameter logic [19:0] ORDER_Q = 20'd166667;
  parameter logic [16:0] FOLD_P  = 17'd48573;
  parameter logic [16:0] FOLD_Q  = 17'd95477;

  parameter int MAX_THRESHOLD = 5;
  parameter int MAX_PARTIES   = 1023;

  // Register indexes
  parameter logic [2:0] REG_GEN_G     = 3'd0;
  parameter logic [2:0] REG_GEN_H     = 3'd1;
  parameter logic [2:0] REG_THRESHOLD = 3'd2;
  parameter logic [2:0] REG_COEFF_0   = 3'd3;
  parameter logic [2:0] REG_COEFF_1   = 3'd4;
  parameter logic [2:0] REG_COEFF_2   = 3'd5;
  parameter logic [2:0] REG_COEFF_3   = 3'd6;
  parameter logic [2:0] REG_COEFF_4   = 3'd7;

  parameter logic [19:0] RST_GEN_G     = 20'd14;
  parameter logic [19:0] RST_GEN_H     = 20'd114;
  parameter logic [2:0]  RST_THRESHOLD = 3'd5;
  parameter logic [19:0] RST_COEFF     = 20'd1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_POW_INIT, ST_POW_TEST, ST_ACC_WAIT, ST_SQ_GO,
    ST_SQ_WAIT, ST_COMB_WAIT, ST_NEXT, ST_IPOW_WAIT, ST_DONE
  } ctrl_state_t;

  typedef enum logic [1:0] {PH_G, PH_H, PH_E} phase_t;

  typedef enum logic [2:0] {
    MUL_ACC, MUL_SQ, MUL_COMMIT, MUL_EXP, MUL_IPOW
  } mul_op_t;

  typedef enum logic [1:0] {MM_IDLE, MM_MUL, MM_FOLD, MM_FIX} mm_state_t;

  typedef struct packed {
    logic       load;
    logic       pow_init;
    phase_t     base_sel;
    logic       save_commit;
    logic       mul_start;
    mul_op_t    mul_op;
    logic       exp_shift;
    logic       publish;
    logic [2:0] coeff_sel;
  } cmd_t;

  typedef struct packed {
    logic       exp_zero;
    logic       exp_lsb;
    logic       mul_done;
    logic       op;
    logic [2:0] thr;
  } status_t;

  // One conditional subtract: inputs stay below 2P
  function automatic logic [19:0] red_p(input logic [19:0] x);
    logic [19:0] r;
    r = (x >= GROUP_P) ? (x - GROUP_P) : x;
    return r;
  endfunction

  // One conditional subtract: inputs stay below 2Q
  function automatic logic [17:0] red_q(input logic [17:0] x);
    logic [19:0] w;
    w = {2'b00, x};
    if (w >= ORDER_Q) begin
      w = w - ORDER_Q;
    end
    return w[17:0];
  endfunction

endpackage

// ----- src/pvs_modmul.sv -----
`timescale 1ns / 1ps
module pvs_modmul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        mod_q,
  input  logic [19:0] a,
  input  logic [19:0] b,
  output logic        done,
  output logic [19:0] result
);

  pvs_pkg::mm_state_t state, state_next;
  logic [19:0] a_r, b_r;
  logic        q_r;
  logic [40:0] r;
  logic [22:0] hi;
  logic [19:0] lo;
  logic [16:0] fold_c;
  logic [19:0] modulus;

  // Split point and fold constant per modulus
  always_comb begin
    hi      = q_r ? r[40:18] : {2'b00, r[40:20]};
    lo      = q_r ? {2'b00, r[17:0]} : r[19:0];
    fold_c  = q_r ? pvs_pkg::FOLD_Q : pvs_pkg::FOLD_P;
    modulus = q_r ? pvs_pkg::ORDER_Q : pvs_pkg::GROUP_P;
  end

  // Sequencer: multiply, fold high part down, final subtract
  always_comb begin
    state_next = state;
    done       = 1'b0;
    case (state)
      pvs_pkg::MM_IDLE: if (start) state_next = pvs_pkg::MM_MUL;
      pvs_pkg::MM_MUL:  state_next = pvs_pkg::MM_FOLD;
      pvs_pkg::MM_FOLD: if (hi == 23'd0) state_next = pvs_pkg::MM_FIX;
      pvs_pkg::MM_FIX: begin
        done       = 1'b1;
        state_next = pvs_pkg::MM_IDLE;
      end
      default: state_next = pvs_pkg::MM_IDLE;
    endcase
  end

  assign result = (r[19:0] >= modulus) ? (r[19:0] - modulus) : r[19:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pvs_pkg::MM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Operand and working registers
  always_ff @(posedge clk) begin
    if (state == pvs_pkg::MM_IDLE && start) begin
      a_r <= a;
      b_r <= b;
      q_r <= mod_q;
    end
    if (state == pvs_pkg::MM_MUL) begin
      r <= 41'(a_r * b_r);
    end else if (state == pvs_pkg::MM_FOLD && hi != 23'd0) begin
      r <= 41'(hi * fold_c) + 41'(lo);
    end
  end

endmodule

// ----- src/pvs_datapath.sv -----
`timescale 1ns / 1ps
module pvs_datapath (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [2:0]       cfg_index,
  input  logic [19:0]      cfg_data,
  input  logic             operation,
  input  logic [9:0]       share_index,
  input  logic [17:0]      secret_part,
  input  logic [17:0]      blinding_part,
  input  pvs_pkg::cmd_t    cmd,
  output pvs_pkg::status_t status,
  output logic [19:0]      commit_value,
  output logic [19:0]      expected_value,
  output logic             share_valid
);

  // Configuration registers
  logic [19:0] gen_g, gen_h, coeff0;
  logic [19:0] coeff_hi [0:3];
  logic [2:0]  thr;

  // Working registers
  logic        op_r;
  logic [9:0]  idx_r;
  logic [17:0] s_r, t_r, pexp, ipow;
  logic [19:0] pacc, psq, commit_r, expected_r;
  pvs_pkg::mul_op_t dest_op;

  logic [19:0] mul_a, mul_b, mul_res;
  logic        mul_q, mul_done;
  logic [2:0]  j_m1;
  logic [19:0] coeff_sel_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_g       <= pvs_pkg::RST_GEN_G;
      gen_h       <= pvs_pkg::RST_GEN_H;
      thr         <= pvs_pkg::RST_THRESHOLD;
      coeff0      <= pvs_pkg::RST_COEFF;
      coeff_hi[0] <= pvs_pkg::RST_COEFF;
      coeff_hi[1] <= pvs_pkg::RST_COEFF;
      coeff_hi[2] <= pvs_pkg::RST_COEFF;
      coeff_hi[3] <= pvs_pkg::RST_COEFF;
    end else if (cfg_write) begin
      case (cfg_index)
        pvs_pkg::REG_GEN_G:     gen_g       <= cfg_data;
        pvs_pkg::REG_GEN_H:     gen_h       <= cfg_data;
        pvs_pkg::REG_THRESHOLD: thr         <= cfg_data[2:0];
        pvs_pkg::REG_COEFF_0:   coeff0      <= cfg_data;
        pvs_pkg::REG_COEFF_1:   coeff_hi[0] <= cfg_data;
        pvs_pkg::REG_COEFF_2:   coeff_hi[1] <= cfg_data;
        pvs_pkg::REG_COEFF_3:   coeff_hi[2] <= cfg_data;
        pvs_pkg::REG_COEFF_4:   coeff_hi[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Coefficient commitment for the current term j (1..4)
  assign j_m1          = cmd.coeff_sel - 3'd1;
  assign coeff_sel_val = coeff_hi[j_m1[1:0]];

  // Multiplier operand select
  always_comb begin
    mul_q = 1'b0;
    case (cmd.mul_op)
      pvs_pkg::MUL_ACC:    begin mul_a = pacc;       mul_b = psq;  end
      pvs_pkg::MUL_SQ:     begin mul_a = psq;        mul_b = psq;  end
      pvs_pkg::MUL_COMMIT: begin mul_a = commit_r;   mul_b = pacc; end
      pvs_pkg::MUL_EXP:    begin mul_a = expected_r; mul_b = pacc; end
      pvs_pkg::MUL_IPOW: begin
        mul_a = {2'b00, ipow};
        mul_b = {10'd0, idx_r};
        mul_q = 1'b1;
      end
      default:             begin mul_a = pacc;       mul_b = psq;  end
    endcase
  end

  pvs_modmul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mul_start),
    .mod_q  (mul_q),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  // Item registers and exponentiation state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= operation;
      idx_r      <= share_index;
      s_r        <= pvs_pkg::red_q(secret_part);
      t_r        <= pvs_pkg::red_q(blinding_part);
      expected_r <= pvs_pkg::red_p(coeff0);
      ipow       <= 18'd1;
    end
    if (cmd.pow_init) begin
      pacc <= 20'd1;
      case (cmd.base_sel)
        pvs_pkg::PH_G: begin psq <= pvs_pkg::red_p(gen_g); pexp <= s_r; end
        pvs_pkg::PH_H: begin psq <= pvs_pkg::red_p(gen_h); pexp <= t_r; end
        default:       begin psq <= pvs_pkg::red_p(coeff_sel_val); pexp <= ipow; end
      endcase
    end
    if (cmd.save_commit) begin
      commit_r <= pacc;
    end
    if (cmd.exp_shift) begin
      pexp <= {1'b0, pexp[17:1]};
    end
    if (cmd.mul_start) begin
      dest_op <= cmd.mul_op;
    end
    if (mul_done) begin
      case (dest_op)
        pvs_pkg::MUL_ACC:    pacc       <= mul_res;
        pvs_pkg::MUL_SQ:     psq        <= mul_res;
        pvs_pkg::MUL_COMMIT: commit_r   <= mul_res;
        pvs_pkg::MUL_EXP:    expected_r <= mul_res;
        pvs_pkg::MUL_IPOW:   ipow       <= mul_res[17:0];
        default: ;
      endcase
    end
    // Output register
    if (cmd.publish) begin
      commit_value   <= commit_r;
      expected_value <= op_r ? expected_r : 20'd0;
      share_valid    <= op_r && (idx_r != 10'd0) &&
                        (int'(idx_r) <= pvs_pkg::MAX_PARTIES) &&
                        (expected_r == commit_r);
    end
  end

  // Status back to the controller; threshold clamped to 1..MAX_THRESHOLD
  always_comb begin
    status.exp_zero = (pexp == 18'd0);
    status.exp_lsb  = pexp[0];
    status.mul_done = mul_done;
    status.op       = op_r;
    if (thr == 3'd0) begin
      status.thr = 3'd1;
    end else if (int'(thr) > pvs_pkg::MAX_THRESHOLD) begin
      status.thr = 3'(pvs_pkg::MAX_THRESHOLD);
    end else begin
      status.thr = thr;
    end
  end

endmodule

// ----- src/pvs_controller.sv -----
`timescale 1ns / 1ps
module pvs_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  pvs_pkg::status_t status,
  output pvs_pkg::cmd_t    cmd
);

  pvs_pkg::ctrl_state_t state, state_next;
  pvs_pkg::phase_t      phase, phase_next;
  logic [2:0]           j, j_next;
  logic                 out_valid_next;

  assign in_stall = (state != pvs_pkg::ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next    = state;
    phase_next    = phase;
    j_next        = j;
    cmd           = '0;
    cmd.base_sel  = phase;
    cmd.coeff_sel = j;
    cmd.mul_op    = pvs_pkg::MUL_ACC;
    case (state)
      pvs_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          phase_next = pvs_pkg::PH_G;
          state_next = pvs_pkg::ST_POW_INIT;
        end
      end
      pvs_pkg::ST_POW_INIT: begin
        cmd.pow_init = 1'b1;
        state_next   = pvs_pkg::ST_POW_TEST;
      end
      pvs_pkg::ST_POW_TEST: begin
        if (status.exp_zero) begin
          case (phase)
            pvs_pkg::PH_G: begin
              cmd.save_commit = 1'b1;
              phase_next      = pvs_pkg::PH_H;
              state_next      = pvs_pkg::ST_POW_INIT;
            end
            pvs_pkg::PH_H: begin
              cmd.mul_start = 1'b1;
              cmd.mul_op    = pvs_pkg::MUL_COMMIT;
              state_next    = pvs_pkg::ST_COMB_WAIT;
            end
            default: begin
              cmd.mul_start = 1'b1;
              cmd.mul_op    = pvs_pkg::MUL_EXP;
              state_next    = pvs_pkg::ST_COMB_WAIT;
            end
          endcase
        end else if (status.exp_lsb) begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = pvs_pkg::MUL_ACC;
          state_next    = pvs_pkg::ST_ACC_WAIT;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = pvs_pkg::MUL_SQ;
          state_next    = pvs_pkg::ST_SQ_WAIT;
        end
      end
      pvs_pkg::ST_ACC_WAIT: begin
        if (status.mul_done) state_next = pvs_pkg::ST_SQ_GO;
      end
      pvs_pkg::ST_SQ_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_op    = pvs_pkg::MUL_SQ;
        state_next    = pvs_pkg::ST_SQ_WAIT;
      end
      pvs_pkg::ST_SQ_WAIT: begin
        if (status.mul_done) begin
          cmd.exp_shift = 1'b1;
          state_next    = pvs_pkg::ST_POW_TEST;
        end
      end
      pvs_pkg::ST_COMB_WAIT: begin
        if (status.mul_done) begin
          if (phase == pvs_pkg::PH_H) begin
            j_next     = 3'd1;
            state_next = status.op ? pvs_pkg::ST_NEXT : pvs_pkg::ST_DONE;
          end else begin
            j_next     = j + 3'd1;
            state_next = pvs_pkg::ST_NEXT;
          end
        end
      end
      pvs_pkg::ST_NEXT: begin
        if (j < status.thr) begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = pvs_pkg::MUL_IPOW;
          state_next    = pvs_pkg::ST_IPOW_WAIT;
        end else begin
          state_next = pvs_pkg::ST_DONE;
        end
      end
      pvs_pkg::ST_IPOW_WAIT: begin
        if (status.mul_done) begin
          phase_next = pvs_pkg::PH_E;
          state_next = pvs_pkg::ST_POW_INIT;
        end
      end
      pvs_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.publish = 1'b1;
          state_next  = pvs_pkg::ST_IDLE;
        end
      end
      default: state_next = pvs_pkg::ST_IDLE;
    endcase
  end

  // Output beat flag
  always_comb begin
    if (cmd.publish) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pvs_pkg::ST_IDLE;
      phase     <= pvs_pkg::PH_G;
      j         <= 3'd1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      j         <= j_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- src/pedersen_share_verifier_unit.sv -----
`timescale 1ns / 1ps
// Pedersen share verifier.
// Input channel (in_valid/in_stall) takes one share beat: operation, share_index,
// secret_part, blinding_part. The unit works one share at a time; in_stall is
// high from the accepting edge until the result is written to the output register.
// Output channel (out_valid/out_stall) carries commit_value, expected_value and
// share_valid; a stalled beat holds, and the next share is taken while it waits.
// Config port (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready; write only
// while idle.
// Every modular product runs on one shared multiplier and passes through start,
// multiply, a fold while the high part is nonzero, fold check and final subtract;
// each exponent bit costs one square, plus a multiply when the bit is set, and a
// test step. Verify mode adds up to four more exponentiations plus index products
// to the work of a commit-only share.
// Reset (rst, synchronous) returns configuration to its defaults, empties the
// output register and leaves the unit idle.
module pedersen_share_verifier_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [9:0]  share_index,
  input  logic [17:0] secret_part,
  input  logic [17:0] blinding_part,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [19:0] commit_value,
  output logic [19:0] expected_value,
  output logic        share_valid
);

  pvs_pkg::cmd_t    cmd;
  pvs_pkg::status_t status;

  assign cfg_ready = 1'b1;

  pvs_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  pvs_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .operation      (operation),
    .share_index    (share_index),
    .secret_part    (secret_part),
    .blinding_part  (blinding_part),
    .cmd            (cmd),
    .status         (status),
    .commit_value   (commit_value),
    .expected_value (expected_value),
    .share_valid    (share_valid)
  );

endmodule

// ----- src/pvs_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pvs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [19:0] commit_value,
  input logic [19:0] expected_value,
  input logic        share_valid
);

  // A taken share keeps the unit busy
  `PVS_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

  // A valid share means both values agree
  `PVS_ASSERT_NOW(a_valid_match, clk, rst, out_valid && share_valid, commit_value == expected_value)

  // A result only appears out of a share in work
  `PVS_ASSERT_NOW(a_result_from_work, clk, rst, $rose(out_valid), $past(in_stall))

  // Stalled result beat holds
  `PVS_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && out_stall, out_valid && $stable(commit_value) && $stable(share_valid))

endmodule

bind pedersen_share_verifier_unit pvs_checker u_pvs_checker (.*);

// ----- dv/pedersen_share_verifier_unit_tb.sv -----
`timescale 1ns / 1ps
module pedersen_share_verifier_unit_tb;

  localparam int LIMIT_CYCLES = 6000000;
  localparam longint PM = 1000003;
  localparam longint QM = 166667;

  typedef struct packed {
    logic [19:0] commit;
    logic [19:0] expect_v;
    logic        valid;
  } share_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        operation = 1'b0;
  logic [9:0]  share_index = '0;
  logic [17:0] secret_part = '0;
  logic [17:0] blinding_part = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [19:0] commit_value;
  logic [19:0] expected_value;
  logic        share_valid;

  // shadow of the register file
  logic [19:0] sh_regs [8];
  share_result_t pending_results[$];
  int fail_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  pedersen_share_verifier_unit i_dut (.*);

  always #10 clk = ~clk;

  function automatic longint pow_mod_p(longint base, longint ex);
    longint acc, sq;
    acc = 1;
    sq = base % PM;
    while (ex != 0) begin
      if (ex[0]) acc = (acc * sq) % PM;
      sq = (sq * sq) % PM;
      ex = ex >> 1;
    end
    return acc;
  endfunction

  function automatic share_result_t predict_share(logic op, logic [9:0] idx,
                                                  logic [17:0] s, logic [17:0] t);
    share_result_t r;
    longint c, x, ip, k;
    c = (pow_mod_p(sh_regs[pvs_pkg::REG_GEN_G], s % QM) *
         pow_mod_p(sh_regs[pvs_pkg::REG_GEN_H], t % QM)) % PM;
    r = '0;
    r.commit = c[19:0];
    if (op) begin
      k = sh_regs[pvs_pkg::REG_THRESHOLD];
      if (k < 1) k = 1;
      if (k > pvs_pkg::MAX_THRESHOLD) k = pvs_pkg::MAX_THRESHOLD;
      x = sh_regs[pvs_pkg::REG_COEFF_0] % PM;
      ip = 1;
      for (int j = 1; j < k; j++) begin
        ip = (ip * idx) % QM;
        x = (x * pow_mod_p(sh_regs[pvs_pkg::REG_COEFF_0 + j], ip)) % PM;
      end
      r.expect_v = x[19:0];
      r.valid = (idx >= 1) && (idx <= pvs_pkg::MAX_PARTIES) && (x == c);
    end
    return r;
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver stall
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    share_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat");
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if (commit_value !== e.commit) begin
          $error("commit_value exp %0d got %0d", e.commit, commit_value);
          fail_count++;
        end
        if (expected_value !== e.expect_v) begin
          $error("expected_value exp %0d got %0d", e.expect_v, expected_value);
          fail_count++;
        end
        if (share_valid !== e.valid) begin
          $error("share_valid exp %0d got %0d", e.valid, share_valid);
          fail_count++;
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [19:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sh_regs[idx] = (idx == pvs_pkg::REG_THRESHOLD) ? {17'd0, val[2:0]} : val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // one share beat
  task automatic send_share(logic op, logic [9:0] idx, logic [17:0] s, logic [17:0] t);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid <= 1'b1;
    operation <= op;
    share_index <= idx;
    secret_part <= s;
    blinding_part <= t;
    do @(posedge clk); while (in_stall);
    pending_results = {pending_results, predict_share(op, idx, s, t)};
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic test_directed_edges;
    send_share(1'b0, 10'd1, 18'd0, 18'd0);
    send_share(1'b1, 10'd1, 18'd0, 18'd0);
    send_share(1'b1, 10'd0, 18'd5, 18'd7);
    send_share(1'b1, 10'd1023, 18'h3FFFF, 18'h3FFFF);
    send_share(1'b0, 10'd1023, 18'd166666, 18'd166667);
    send_share(1'b1, 10'd512, 18'd166667, 18'd1);
    drain();
    // zero bases and unreduced values
    write_reg(pvs_pkg::REG_GEN_G, 20'd0);
    write_reg(pvs_pkg::REG_GEN_H, 20'hFFFFF);
    write_reg(pvs_pkg::REG_THRESHOLD, 20'd0);
    write_reg(pvs_pkg::REG_COEFF_0, 20'd1000003);
    send_share(1'b1, 10'd3, 18'd0, 18'd9);
    send_share(1'b1, 10'd3, 18'd4, 18'd0);
    drain();
    write_reg(pvs_pkg::REG_THRESHOLD, 20'd7);
    for (int j = 0; j < 5; j++) write_reg(3'(pvs_pkg::REG_COEFF_0 + j), 20'd0);
    send_share(1'b1, 10'd2, 18'd1, 18'd1);
    drain();
  endtask

  // a matching share: commitments built so valid can come out 1
  task automatic test_valid_share;
    write_reg(pvs_pkg::REG_GEN_G, 20'd14);
    write_reg(pvs_pkg::REG_GEN_H, 20'd114);
    write_reg(pvs_pkg::REG_THRESHOLD, 20'd1);
    write_reg(pvs_pkg::REG_COEFF_0, 20'(pow_mod_p(14, 123) * pow_mod_p(114, 456) % PM));
    send_share(1'b1, 10'd9, 18'd123, 18'd456);
    send_share(1'b1, 10'd0, 18'd123, 18'd456);
    send_share(1'b1, 10'd1023, 18'd123, 18'd456);
    drain();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 25 == 0) begin
        drain();
        for (int r = 0; r < 8; r++) begin
          case ($urandom_range(3))
            0: write_reg(r[2:0], 20'($urandom_range(1000002)));
            1: write_reg(r[2:0], 20'($urandom()));
            2: write_reg(r[2:0], 20'($urandom_range(5, 1)));
            default: ;
          endcase
        end
      end
      send_share(1'($urandom_range(1)), 10'($urandom()), 18'($urandom()),
                 ($urandom_range(3) == 0) ? 18'($urandom()) : 18'($urandom_range(255)));
    end
  endtask

  initial begin
    for (int r = 0; r < 8; r++) sh_regs[r] = pvs_pkg::RST_COEFF;
    sh_regs[pvs_pkg::REG_GEN_G] = pvs_pkg::RST_GEN_G;
    sh_regs[pvs_pkg::REG_GEN_H] = pvs_pkg::RST_GEN_H;
    sh_regs[pvs_pkg::REG_THRESHOLD] = {17'd0, pvs_pkg::RST_THRESHOLD};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_share(1'b1, 10'd5, 18'd77, 18'd88);
    drain();
    test_directed_edges();
    test_valid_share();
    test_random(130);
    send_idle_pct = 88;
    test_random(120);
    send_idle_pct = 0;
    recv_stall_pct = 88;
    test_random(120);
    send_idle_pct = 28;
    recv_stall_pct = 28;
    test_random(120);
    drain();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/pvs_pkg.sv
src/pvs_modmul.sv
src/pvs_datapath.sv
src/pvs_controller.sv
src/pedersen_share_verifier_unit.sv
src/pvs_checker.sv
dv/pedersen_share_verifier_unit_tb.sv
